@@ src/affine_2d_matrix_inverse_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the affine 2D matrix inverse
// Shared property forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef AFFINE_2D_MATRIX_INVERSE_TOP_DEFINES_SVH
`define AFFINE_2D_MATRIX_INVERSE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AD2MI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define AD2MI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ad2mi_pkg.sv @@
// ---------------------------------------------------------------------------
// ad2mi_pkg
// Types, constants and divider step functions for the affine inverse.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ad2mi_pkg;

  localparam int NUM_LANES  = 6;
  localparam int NUM_STEPS  = 32;
  // products, differences, divider setup, divider steps, output register
  localparam int NUM_STAGES = NUM_STEPS + 4;

  localparam logic [15:0] THRESH_RESET = 16'd43;
  localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
  localparam logic [31:0] SAT_POS      = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG      = 32'h8000_0000;

  typedef struct packed {
    logic [63:0] ad;
    logic [63:0] bc;
    logic [63:0] bty;
    logic [63:0] dtx;
    logic [63:0] ctx;
    logic [63:0] aty;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } prod_t;

  typedef struct packed {
    logic [63:0] det;
    logic [63:0] nx;
    logic [63:0] ny;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } diff_t;

  // lq holds the dividend bits still to shift in; quotient bits fill from the bottom
  typedef struct packed {
    logic        neg;
    logic        big;
    logic [63:0] rem;
    logic [31:0] lq;
  } div_lane_t;

  typedef struct packed {
    logic                            sing;
    logic [63:0]                     dm;
    div_lane_t [NUM_LANES-1:0]       lane;
  } div_stage_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } fin_t;

  function automatic div_lane_t lane_init(logic nneg, logic [63:0] nmag, logic sh16,
                                          logic dneg, logic [63:0] dm);
    div_lane_t   l;
    logic [63:0] hi;
    hi    = sh16 ? {16'b0, nmag[63:16]} : nmag;
    l.neg = nneg ^ dneg;
    // quotient of 2^32 or more always saturates
    l.big = (hi >= dm);
    l.rem = hi;
    l.lq  = sh16 ? {nmag[15:0], 16'b0} : 32'b0;
    return l;
  endfunction

  function automatic div_lane_t lane_step(div_lane_t l, logic [63:0] dm);
    div_lane_t   r;
    logic [64:0] t;
    logic        qb;
    t  = {l.rem, l.lq[31]};
    qb = (t >= {1'b0, dm});
    if (qb) begin
      t = t - {1'b0, dm};
    end
    r.neg = l.neg;
    r.big = l.big;
    r.rem = t[63:0];
    r.lq  = {l.lq[30:0], qb};
    return r;
  endfunction

  function automatic div_stage_t stage_step(div_stage_t s);
    div_stage_t r;
    r = s;
    for (int i = 0; i < NUM_LANES; i++) begin
      r.lane[i] = lane_step(s.lane[i], s.dm);
    end
    return r;
  endfunction

  function automatic fin_t lane_finish(div_lane_t l);
    fin_t f;
    logic over;
    over  = l.neg ? (l.lq > SAT_NEG) : (l.lq > SAT_POS);
    f.ovf = l.big || over;
    if (f.ovf) begin
      f.val = l.neg ? SAT_NEG : SAT_POS;
    end else begin
      f.val = l.neg ? (32'd0 - l.lq) : l.lq;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

@@ src/affine_2d_matrix_inverse_top.sv @@
// ---------------------------------------------------------------------------
// affine_2d_matrix_inverse_top
// Inverse of a 2D affine matrix in signed Q16.16 with singular detection.
// ---------------------------------------------------------------------------
// Accepts one matrix per cycle when the output does not stall and returns its
// inverse from a six-lane restoring divider: one quotient bit per stage over
// 32 stages, after two stages of products and differences and one setup
// stage. Stages with no valid item close up under a stall, so the block keeps
// taking transactions while a result waits, until every stage is full. A
// matrix whose determinant magnitude is zero or below the threshold loaded
// from cfg_wr_data returns the identity with singular set.
`timescale 1ns / 1ps
`default_nettype none

module affine_2d_matrix_inverse_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_xx,
  input  wire logic [31:0] in_xy,
  input  wire logic [31:0] in_yx,
  input  wire logic [31:0] in_yy,
  input  wire logic [31:0] in_tx,
  input  wire logic [31:0] in_ty,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_xx,
  output logic [31:0]      out_xy,
  output logic [31:0]      out_yx,
  output logic [31:0]      out_yy,
  output logic [31:0]      out_tx,
  output logic [31:0]      out_ty,
  output logic             singular,
  output logic             overflow
);

  localparam int LAST = ad2mi_pkg::NUM_STAGES - 1;

  logic [15:0]                     thresh;
  logic [ad2mi_pkg::NUM_STAGES-1:0] vld;
  logic [ad2mi_pkg::NUM_STAGES-1:0] en;
  ad2mi_pkg::prod_t                p1;
  ad2mi_pkg::diff_t                p2;
  ad2mi_pkg::div_stage_t           st [0:ad2mi_pkg::NUM_STEPS];
  ad2mi_pkg::div_stage_t           st0_next;
  ad2mi_pkg::fin_t                 fin [ad2mi_pkg::NUM_LANES];
  logic                            fin_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= ad2mi_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh <= cfg_wr_data;
    end
  end

  // a stage loads when it is empty or its content moves on
  assign en[LAST] = !vld[LAST] || out_ready;
  for (genvar i = 0; i < LAST; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end
  assign in_ready  = en[0];
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < ad2mi_pkg::NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1.ad  <= 64'($signed(in_xx)) * 64'($signed(in_yy));
      p1.bc  <= 64'($signed(in_xy)) * 64'($signed(in_yx));
      p1.bty <= 64'($signed(in_xy)) * 64'($signed(in_ty));
      p1.dtx <= 64'($signed(in_yy)) * 64'($signed(in_tx));
      p1.ctx <= 64'($signed(in_yx)) * 64'($signed(in_tx));
      p1.aty <= 64'($signed(in_xx)) * 64'($signed(in_ty));
      p1.a   <= in_xx;
      p1.b   <= in_xy;
      p1.c   <= in_yx;
      p1.d   <= in_yy;
    end
  end

  // determinant and translation numerators
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p2.det <= p1.ad - p1.bc;
      p2.nx  <= p1.bty - p1.dtx;
      p2.ny  <= p1.ctx - p1.aty;
      p2.a   <= p1.a;
      p2.b   <= p1.b;
      p2.c   <= p1.c;
      p2.d   <= p1.d;
    end
  end

  // divider setup
  always_comb begin
    logic [63:0] dm;
    logic        dn;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] mc;
    logic [31:0] md;
    logic [63:0] mnx;
    logic [63:0] mny;
    dn  = p2.det[63];
    dm  = dn ? (64'd0 - p2.det) : p2.det;
    ma  = p2.a[31] ? (32'd0 - p2.a) : p2.a;
    mb  = p2.b[31] ? (32'd0 - p2.b) : p2.b;
    mc  = p2.c[31] ? (32'd0 - p2.c) : p2.c;
    md  = p2.d[31] ? (32'd0 - p2.d) : p2.d;
    mnx = p2.nx[63] ? (64'd0 - p2.nx) : p2.nx;
    mny = p2.ny[63] ? (64'd0 - p2.ny) : p2.ny;
    st0_next.sing    = (dm == 64'd0) || (dm < {48'd0, thresh});
    st0_next.dm      = dm;
    st0_next.lane[0] = ad2mi_pkg::lane_init(p2.d[31], {32'd0, md}, 1'b0, dn, dm);
    st0_next.lane[1] = ad2mi_pkg::lane_init(!p2.b[31] && (p2.b != 32'd0),
                                            {32'd0, mb}, 1'b0, dn, dm);
    st0_next.lane[2] = ad2mi_pkg::lane_init(!p2.c[31] && (p2.c != 32'd0),
                                            {32'd0, mc}, 1'b0, dn, dm);
    st0_next.lane[3] = ad2mi_pkg::lane_init(p2.a[31], {32'd0, ma}, 1'b0, dn, dm);
    st0_next.lane[4] = ad2mi_pkg::lane_init(p2.nx[63], mnx, 1'b1, dn, dm);
    st0_next.lane[5] = ad2mi_pkg::lane_init(p2.ny[63], mny, 1'b1, dn, dm);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      st[0] <= st0_next;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= ad2mi_pkg::NUM_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[k+2]) begin
        st[k] <= ad2mi_pkg::stage_step(st[k-1]);
      end
    end
  end

  always_comb begin
    fin_ovf = 1'b0;
    for (int i = 0; i < ad2mi_pkg::NUM_LANES; i++) begin
      fin[i]  = ad2mi_pkg::lane_finish(st[ad2mi_pkg::NUM_STEPS].lane[i]);
      fin_ovf = fin_ovf | fin[i].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      if (st[ad2mi_pkg::NUM_STEPS].sing) begin
        out_xx   <= ad2mi_pkg::ONE_Q16;
        out_xy   <= 32'd0;
        out_yx   <= 32'd0;
        out_yy   <= ad2mi_pkg::ONE_Q16;
        out_tx   <= 32'd0;
        out_ty   <= 32'd0;
        singular <= 1'b1;
        overflow <= 1'b0;
      end else begin
        out_xx   <= fin[0].val;
        out_xy   <= fin[1].val;
        out_yx   <= fin[2].val;
        out_yy   <= fin[3].val;
        out_tx   <= fin[4].val;
        out_ty   <= fin[5].val;
        singular <= 1'b0;
        overflow <= fin_ovf;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/ad2mi_checker.sv @@
// ---------------------------------------------------------------------------
// ad2mi_checker
// Port-level checks for the affine inverse, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "affine_2d_matrix_inverse_top_defines.svh"

module ad2mi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_xx,
  input wire logic [31:0] out_xy,
  input wire logic [31:0] out_yx,
  input wire logic [31:0] out_yy,
  input wire logic [31:0] out_tx,
  input wire logic [31:0] out_ty,
  input wire logic        singular,
  input wire logic        overflow
);

  `AD2MI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_xx) && $stable(out_tx) && $stable(singular), "stalled result changed")
  `AD2MI_ASSERT_NOW(a_sing_diag, out_valid && singular, out_xx == 32'h0001_0000 && out_yy == 32'h0001_0000, "singular result not identity")
  `AD2MI_ASSERT_NOW(a_sing_off, out_valid && singular, out_xy == 32'd0 && out_yx == 32'd0 && out_tx == 32'd0 && out_ty == 32'd0, "singular result has off-diagonal terms")
  `AD2MI_ASSERT_NOW(a_sing_ovf, out_valid && singular, !overflow, "overflow set on singular result")

endmodule

bind affine_2d_matrix_inverse_top ad2mi_checker u_ad2mi_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_xx    (out_xx),
  .out_xy    (out_xy),
  .out_yx    (out_yx),
  .out_yy    (out_yy),
  .out_tx    (out_tx),
  .out_ty    (out_ty),
  .singular  (singular),
  .overflow  (overflow)
);

`default_nettype wire
